### rtl/bpc_pkg.sv
// shared widths, register indexes and stage transaction types for the pressure compensation
package bpc_pkg;

    // field widths
    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int TMP_W   = 19;
    localparam int PRES_W  = 32;

    // internal widths
    localparam int DT_W    = 26;  // raw temperature minus scaled reference
    localparam int Q_W     = 20;  // first-order temperature minus 2000
    localparam int T2_W    = 18;  // dt squared over 2^31
    localparam int SQ_W    = 36;  // squared temperature terms
    localparam int OS_W    = 40;  // offset and sensitivity

    // temperature thresholds relative to 20.00 C
    localparam int TEMP_REF      = 2000;
    localparam int TEMP_COLD_OFS = 3500;  // -15.00 C lies 35.00 C below 20.00 C

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PSENS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STC    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OTC    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TREF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TSLOPE = 3'd5;

    typedef struct packed {
        logic [CAL_W-1:0] psens;
        logic [CAL_W-1:0] poff;
        logic [CAL_W-1:0] stc;
        logic [CAL_W-1:0] otc;
        logic [CAL_W-1:0] tref;
        logic [CAL_W-1:0] tslope;
    } cal_t;

    typedef struct packed {
        logic        [RAW_W-1:0] d1;
        logic signed [Q_W-1:0]   q;
        logic        [T2_W-1:0]  t2;
        logic signed [OS_W-1:0]  off1;
        logic signed [OS_W-1:0]  sens1;
    } first_t;

    typedef struct packed {
        logic        [RAW_W-1:0] d1;
        logic signed [TMP_W-1:0] temp;
        logic signed [OS_W-1:0]  off;
        logic signed [OS_W-1:0]  sens;
    } comp_t;

endpackage

### rtl/barometric_pressure_compensation.sv
// throughput: one transaction per cycle while m_ready is high; the ten-stage pipeline with
//   its multiplier stages sets this, and bubbles close up while the output is stalled
// reset: synchronous active-low aresetn clears all stage valid bits and the six
//   calibration registers to zero; payload registers are not reset
// the configuration channel is always ready and must only be written while the pipeline is empty
module barometric_pressure_compensation (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // calibration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bpc_pkg::CAL_W-1:0]            cfg_data,
    // raw conversion transactions
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [bpc_pkg::RAW_W-1:0]            s_raw_pressure,
    input  logic [bpc_pkg::RAW_W-1:0]            s_raw_temperature,
    // compensated result transactions
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [bpc_pkg::TMP_W-1:0]     m_temperature_centi,
    output logic signed [bpc_pkg::PRES_W-1:0]    m_pressure_centi
);
    import bpc_pkg::*;

    // calibration words, held steady by the user while transactions are in flight, unenforced
    cal_t   cal_reg, cal_next;

    // inter-module transactions
    logic   fr_valid, cr_ready;
    first_t fr_data;
    logic   cr_valid, pr_ready;
    comp_t  cr_data;

    assign cfg_ready = 1'b1;

    // register writes; indexes beyond the last word are dropped
    always_comb begin
        cal_next = cal_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PSENS:  cal_next.psens  = cfg_data;
                CFG_POFF:   cal_next.poff   = cfg_data;
                CFG_STC:    cal_next.stc    = cfg_data;
                CFG_OTC:    cal_next.otc    = cfg_data;
                CFG_TREF:   cal_next.tref   = cfg_data;
                CFG_TSLOPE: cal_next.tslope = cfg_data;
                default:    cal_next        = cal_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

    // stages one to three: dt, calibration products and first-order temperature
    bpc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cal             (cal_reg),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .raw_pressure    (s_raw_pressure),
        .raw_temperature (s_raw_temperature),
        .out_valid       (fr_valid),
        .out_ready       (cr_ready),
        .out_data        (fr_data)
    );

    // stages four to six: low-temperature corrections applied to offset and sensitivity
    bpc_corr u_corr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (cr_ready),
        .in_data   (fr_data),
        .out_valid (cr_valid),
        .out_ready (pr_ready),
        .out_data  (cr_data)
    );

    // stages seven to ten: pressure product, scaling, output register
    bpc_press u_press (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (cr_valid),
        .in_ready          (pr_ready),
        .in_data           (cr_data),
        .out_valid         (m_valid),
        .out_ready         (m_ready),
        .temperature_centi (m_temperature_centi),
        .pressure_centi    (m_pressure_centi)
    );

`ifndef ASSERT_OFF
    // with no result waiting, every stage can move, so the input side must be open
    a_idle_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input not ready while output is empty");

    // a transaction stalled between front and correction stages is neither lost nor altered
    a_front_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        fr_valid && !cr_ready |=> fr_valid && $stable(fr_data))
        else $error("front transaction changed while stalled");

    // the same between correction and pressure stages
    a_corr_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cr_valid && !pr_ready |=> cr_valid && $stable(cr_data))
        else $error("correction transaction changed while stalled");
`endif

endmodule

### rtl/bpc_front.sv
// first three stages: temperature difference, calibration products, first-order terms
module bpc_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bpc_pkg::cal_t             cal,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [bpc_pkg::RAW_W-1:0] raw_pressure,
    input  logic [bpc_pkg::RAW_W-1:0] raw_temperature,
    output logic                      out_valid,
    input  logic                      out_ready,
    output bpc_pkg::first_t           out_data
);
    import bpc_pkg::*;

    localparam int PM_W  = DT_W + CAL_W + 1;
    localparam int SQD_W = 2 * DT_W;

    logic [2:0] v_reg;
    logic [3:0] en;

    logic signed [DT_W-1:0]  dt_reg, dt_next;
    logic        [RAW_W-1:0] d1a_reg, d1b_reg;
    logic signed [PM_W-1:0]  p6_reg, p6_next, p4_reg, p4_next, p3_reg, p3_next;
    logic signed [SQD_W-1:0] pdd_reg, pdd_next;
    first_t                  o_reg, o_next;

    logic signed [PM_W-1:0]  p6_adj, p4_adj, p3_adj;
    logic signed [PM_W-8:0]  offt;
    logic signed [PM_W-9:0]  senst;

    assign en[3] = out_ready;
    assign en[2] = !v_reg[2] || en[3];
    assign en[1] = !v_reg[1] || en[2];
    assign en[0] = !v_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = v_reg[2];
    assign out_data  = o_reg;

    always_comb begin
        dt_next = $signed({2'b00, raw_temperature}) - $signed({2'b00, cal.tref, 8'h00});

        p6_next  = dt_reg * $signed({1'b0, cal.tslope});
        p4_next  = dt_reg * $signed({1'b0, cal.otc});
        p3_next  = dt_reg * $signed({1'b0, cal.stc});
        pdd_next = dt_reg * dt_reg;

        // truncating divisions by powers of two: bias negatives before the shift
        p6_adj = p6_reg + $signed({{(PM_W-23){1'b0}}, {23{p6_reg[PM_W-1]}}});
        p4_adj = p4_reg + $signed({{(PM_W-7){1'b0}}, {7{p4_reg[PM_W-1]}}});
        p3_adj = p3_reg + $signed({{(PM_W-8){1'b0}}, {8{p3_reg[PM_W-1]}}});
        offt   = p4_adj[PM_W-1:7];
        senst  = p3_adj[PM_W-1:8];

        o_next.d1    = d1b_reg;
        o_next.q     = p6_adj[PM_W-1:23];
        o_next.t2    = pdd_reg[31+T2_W-1:31];
        o_next.off1  = $signed({{(OS_W-CAL_W-16){1'b0}}, cal.poff, 16'h0000})
                     + OS_W'(offt);
        o_next.sens1 = $signed({{(OS_W-CAL_W-15){1'b0}}, cal.psens, 15'h0000})
                     + OS_W'(senst);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= in_valid;
            end
            if (en[1]) begin
                v_reg[1] <= v_reg[0];
            end
            if (en[2]) begin
                v_reg[2] <= v_reg[1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dt_reg  <= dt_next;
            d1a_reg <= raw_pressure;
        end
        if (en[1]) begin
            p6_reg  <= p6_next;
            p4_reg  <= p4_next;
            p3_reg  <= p3_next;
            pdd_reg <= pdd_next;
            d1b_reg <= d1a_reg;
        end
        if (en[2]) begin
            o_reg <= o_next;
        end
    end

endmodule

### rtl/bpc_corr.sv
// stages four to six: second-order low-temperature terms, final offset and sensitivity
module bpc_corr (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  bpc_pkg::first_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bpc_pkg::comp_t    out_data
);
    import bpc_pkg::*;

    logic [2:0] v_reg;
    logic [3:0] en;

    // stage four
    logic        [SQ_W-1:0]  lo2_reg, lo2_next, vl2_reg, vl2_next;
    logic                    cold_reg, cold_next, frigid_reg, frigid_next;
    logic signed [TMP_W-1:0] t4_reg, t4_next, t5_reg;
    logic        [RAW_W-1:0] d4_reg, d5_reg;
    logic signed [OS_W-1:0]  off4_reg, sens4_reg, off5_reg, sens5_reg;
    // stage five
    logic        [OS_W-1:0]  off2_reg, off2_next, sens2_reg, sens2_next;
    // stage six
    comp_t                   o_reg, o_next;

    logic signed [Q_W:0]     vl;
    logic signed [2*Q_W-1:0] qq;
    logic signed [2*Q_W+1:0] vv;
    logic signed [Q_W+1:0]   tmp;
    logic        [OS_W-1:0]  lo5, vl7, vl11, lo2w, vl2w;

    assign en[3] = out_ready;
    assign en[2] = !v_reg[2] || en[3];
    assign en[1] = !v_reg[1] || en[2];
    assign en[0] = !v_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = v_reg[2];
    assign out_data  = o_reg;

    always_comb begin
        // lo = temp - 2000 is q itself; vl = temp + 1500
        qq  = in_data.q * in_data.q;
        vl  = (Q_W+1)'(in_data.q) + (Q_W+1)'(TEMP_COLD_OFS);
        vv  = vl * vl;
        // t2 only counts below 20.00 C
        tmp = (Q_W+2)'(in_data.q) + (Q_W+2)'(TEMP_REF)
            - (in_data.q[Q_W-1] ? (Q_W+2)'(in_data.t2) : (Q_W+2)'(0));
        lo2_next    = qq[SQ_W-1:0];
        vl2_next    = vv[SQ_W-1:0];
        cold_next   = in_data.q[Q_W-1];
        frigid_next = vl[Q_W];
        t4_next     = tmp[TMP_W-1:0];

        // constant multiples as shift-adds, all terms non-negative
        lo2w = OS_W'(lo2_reg);
        vl2w = OS_W'(vl2_reg);
        lo5  = (lo2w << 2) + lo2w;
        vl7  = (vl2w << 3) - vl2w;
        vl11 = (vl2w << 3) + (vl2w << 1) + vl2w;
        off2_next  = '0;
        sens2_next = '0;
        if (cold_reg) begin
            off2_next  = (lo5 >> 1) + (frigid_reg ? vl7 : '0);
            sens2_next = (lo5 >> 2) + (frigid_reg ? (vl11 >> 1) : '0);
        end

        o_next.d1   = d5_reg;
        o_next.temp = t5_reg;
        o_next.off  = off5_reg - $signed(off2_reg);
        o_next.sens = sens5_reg - $signed(sens2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= in_valid;
            end
            if (en[1]) begin
                v_reg[1] <= v_reg[0];
            end
            if (en[2]) begin
                v_reg[2] <= v_reg[1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            lo2_reg    <= lo2_next;
            vl2_reg    <= vl2_next;
            cold_reg   <= cold_next;
            frigid_reg <= frigid_next;
            t4_reg     <= t4_next;
            d4_reg     <= in_data.d1;
            off4_reg   <= in_data.off1;
            sens4_reg  <= in_data.sens1;
        end
        if (en[1]) begin
            off2_reg  <= off2_next;
            sens2_reg <= sens2_next;
            t5_reg    <= t4_reg;
            d5_reg    <= d4_reg;
            off5_reg  <= off4_reg;
            sens5_reg <= sens4_reg;
        end
        if (en[2]) begin
            o_reg <= o_next;
        end
    end

endmodule

### rtl/bpc_press.sv
// stages seven to ten: split pressure product, scaling and output register
module bpc_press (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  bpc_pkg::comp_t                    in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [bpc_pkg::TMP_W-1:0]  temperature_centi,
    output logic signed [bpc_pkg::PRES_W-1:0] pressure_centi
);
    import bpc_pkg::*;

    localparam int SPL_W = OS_W / 2;
    localparam int PL_W  = RAW_W + SPL_W;
    localparam int PH_W  = RAW_W + SPL_W + 1;
    localparam int PR_W  = 64;
    localparam int A_W   = PR_W - 21 + 1;

    logic [3:0] v_reg;
    logic [4:0] en;

    logic        [PL_W-1:0]   plo_reg, plo_next;
    logic signed [PH_W-1:0]   phi_reg, phi_next;
    logic signed [PR_W-1:0]   prod_reg, prod_next, prod_adj;
    logic signed [A_W-1:0]    a_reg, a_next, a_adj;
    logic signed [PRES_W-1:0] pres_reg, pres_next;
    logic signed [OS_W-1:0]   off7_reg, off8_reg;
    logic signed [TMP_W-1:0]  t7_reg, t8_reg, t9_reg, t10_reg;

    assign en[4] = out_ready;
    assign en[3] = !v_reg[3] || en[4];
    assign en[2] = !v_reg[2] || en[3];
    assign en[1] = !v_reg[1] || en[2];
    assign en[0] = !v_reg[0] || en[1];
    assign in_ready          = en[0];
    assign out_valid         = v_reg[3];
    assign temperature_centi = t10_reg;
    assign pressure_centi    = pres_reg;

    always_comb begin
        // d1 * sens as two partial products on the halves of sens
        plo_next = in_data.d1 * in_data.sens[SPL_W-1:0];
        phi_next = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[OS_W-1:SPL_W]);

        prod_next = ($signed(PR_W'(phi_reg)) <<< SPL_W) + $signed(PR_W'(plo_reg));

        prod_adj = prod_reg + $signed({{(PR_W-21){1'b0}}, {21{prod_reg[PR_W-1]}}});
        a_next   = A_W'($signed(prod_adj[PR_W-1:21])) - A_W'(off8_reg);

        a_adj     = a_reg + $signed({{(A_W-15){1'b0}}, {15{a_reg[A_W-1]}}});
        pres_next = PRES_W'($signed(a_adj[A_W-1:15]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= in_valid;
            end
            if (en[1]) begin
                v_reg[1] <= v_reg[0];
            end
            if (en[2]) begin
                v_reg[2] <= v_reg[1];
            end
            if (en[3]) begin
                v_reg[3] <= v_reg[2];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            off7_reg <= in_data.off;
            t7_reg   <= in_data.temp;
        end
        if (en[1]) begin
            prod_reg <= prod_next;
            off8_reg <= off7_reg;
            t8_reg   <= t7_reg;
        end
        if (en[2]) begin
            a_reg  <= a_next;
            t9_reg <= t8_reg;
        end
        if (en[3]) begin
            pres_reg <= pres_next;
            t10_reg  <= t9_reg;
        end
    end

endmodule
